>>> rtl/brle8_pkg.sv
`default_nettype none

package brle8_pkg;

  localparam int unsigned CFG_W        = 14;
  localparam int unsigned CFG_REG_MAX  = (1 << CFG_W) - 1;
  localparam int unsigned CFG_IDX_W    = 1;
  localparam int unsigned ADDR_W       = 26;

  localparam int unsigned MAX_STRIDE_DEFAULT = 8192;
  localparam int unsigned MAX_ROWS_DEFAULT   = 8192;
  localparam int unsigned RESET_STRIDE       = 4;
  localparam int unsigned RESET_ROWS         = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_ROW_STRIDE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_ROWS = 1'd1;

  localparam logic [7:0] ESC_EOL   = 8'd0;
  localparam logic [7:0] ESC_EOB   = 8'd1;
  localparam logic [7:0] ESC_DELTA = 8'd2;

  typedef struct packed {
    logic [7:0] code_byte;
    logic       last_byte;
  } in_t;

  typedef struct packed {
    logic [ADDR_W-1:0] dest_address;
    logic [7:0]        run_length;
    logic [7:0]        pixel_value;
    logic              finished;
  } out_t;

endpackage

`default_nettype wire

>>> rtl/bmp_rle8_decoder.sv
// A fill command is registered into the output buffer's head entry, or its skid entry while the head is held.
// Throughput: 1 compressed byte per cycle while the output buffer is not full; the parse state updates per byte.
// A two-entry output buffer keeps input flowing while one result waits.
// Reset (async, active low): parse state and addresses clear, row_stride = 4,
// image_rows = 1, output buffer empty.
`default_nettype none

module bmp_rle8_decoder import brle8_pkg::*; #(
  parameter int unsigned MAX_STRIDE = MAX_STRIDE_DEFAULT,
  parameter int unsigned MAX_ROWS   = MAX_ROWS_DEFAULT
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [CFG_W-1:0]     cfg_data_i,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire in_t                  in_data_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output out_t                      out_data_o
);

  logic accept, res_valid, push, pop;
  out_t res;

  logic head_v_q, head_v_d, skid_v_q, skid_v_d;
  out_t head_q, head_d, skid_q, skid_d;

  assign in_ready_o = !skid_v_q;
  assign accept     = in_valid_i && in_ready_o;

  brle8_core #(
    .MAX_STRIDE (MAX_STRIDE),
    .MAX_ROWS   (MAX_ROWS)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .accept_i    (accept),
    .in_data_i   (in_data_i),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  assign push = accept && res_valid;
  assign pop  = head_v_q && out_ready_i;

  always_comb begin
    head_v_d = head_v_q;
    head_d   = head_q;
    skid_v_d = skid_v_q;
    skid_d   = skid_q;
    if (!head_v_q || pop) begin
      if (skid_v_q) begin
        head_v_d = 1'b1;
        head_d   = skid_q;
        skid_v_d = push;
        skid_d   = res;
      end else begin
        head_v_d = push;
        head_d   = res;
      end
    end else if (push) begin
      skid_v_d = 1'b1;
      skid_d   = res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_v_q <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      head_v_q <= head_v_d;
      skid_v_q <= skid_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    head_q <= head_d;
    skid_q <= skid_d;
  end

  assign out_valid_o = head_v_q;
  assign out_data_o  = head_q;

endmodule

`default_nettype wire

>>> rtl/brle8_core.sv
`default_nettype none

module brle8_core import brle8_pkg::*; #(
  parameter int unsigned MAX_STRIDE = MAX_STRIDE_DEFAULT,
  parameter int unsigned MAX_ROWS   = MAX_ROWS_DEFAULT
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [CFG_W-1:0]     cfg_data_i,
  input  wire logic                 accept_i,
  input  wire in_t                  in_data_i,
  output logic                      res_valid_o,
  output out_t                      res_o
);

  localparam int unsigned STRIDE_CAP = (MAX_STRIDE < CFG_REG_MAX) ? MAX_STRIDE : CFG_REG_MAX;
  localparam int unsigned ROWS_CAP   = (MAX_ROWS < CFG_REG_MAX) ? MAX_ROWS : CFG_REG_MAX;
  localparam int unsigned SW         = $clog2(STRIDE_CAP + 1);
  localparam int unsigned RW         = $clog2(ROWS_CAP + 1);
  localparam int unsigned AW         = $clog2(STRIDE_CAP * ROWS_CAP);
  localparam int unsigned END_W      = AW + 1;
  localparam int unsigned SUMW       = END_W + 9;
  localparam int unsigned PRODW      = AW + 1 + SW;

  localparam logic [2:0] PH_COUNT = 3'd0;
  localparam logic [2:0] PH_VALUE = 3'd1;
  localparam logic [2:0] PH_ESC   = 3'd2;
  localparam logic [2:0] PH_DX    = 3'd3;
  localparam logic [2:0] PH_DY    = 3'd4;
  localparam logic [2:0] PH_ABS   = 3'd5;
  localparam logic [2:0] PH_PAD   = 3'd6;

  logic [SW-1:0]    stride_q, stride_d;
  logic [RW-1:0]    rows_q, rows_d;
  logic [END_W-1:0] end_q, end_d;

  logic [2:0]    phase_q, phase_d;
  logic [AW-1:0] addr_q, addr_d;
  logic [AW-1:0] row_q, row_d;
  logic [7:0]    cnt_q, cnt_d;
  logic [7:0]    dx_q, dx_d;
  logic          pad_q, pad_d;

  // register writes, clamped to 1..cap; end of destination follows at once
  always_comb begin
    stride_d = stride_q;
    rows_d   = rows_q;
    if (cfg_we_i && cfg_idx_i == CFG_ROW_STRIDE) begin
      if (cfg_data_i == '0) begin
        stride_d = SW'(1);
      end else if (32'(cfg_data_i) > STRIDE_CAP) begin
        stride_d = SW'(STRIDE_CAP);
      end else begin
        stride_d = SW'(cfg_data_i);
      end
    end
    if (cfg_we_i && cfg_idx_i == CFG_IMAGE_ROWS) begin
      if (cfg_data_i == '0) begin
        rows_d = RW'(1);
      end else if (32'(cfg_data_i) > ROWS_CAP) begin
        rows_d = RW'(ROWS_CAP);
      end else begin
        rows_d = RW'(cfg_data_i);
      end
    end
    end_d = END_W'(END_W'(stride_d) * END_W'(rows_d));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stride_q <= SW'(RESET_STRIDE);
      rows_q   <= RW'(RESET_ROWS);
      end_q    <= END_W'(RESET_STRIDE * RESET_ROWS);
    end else if (cfg_we_i) begin
      stride_q <= stride_d;
      rows_q   <= rows_d;
      end_q    <= end_d;
    end
  end

  logic [7:0]       b;
  logic [SUMW-1:0]  addr_w, end_w, stride_w, room, next_addr, dy_off;
  logic             have, done;
  logic [SUMW-1:0]  f_len;
  logic [7:0]       cnt_dec;
  logic [AW:0]      row_inc;
  logic [PRODW-1:0] eol_prod;

  assign b        = in_data_i.code_byte;
  assign addr_w   = SUMW'(addr_q);
  assign end_w    = SUMW'(end_q);
  assign stride_w = SUMW'(stride_q);
  assign dy_off   = SUMW'(SUMW'(b) * stride_w);
  assign cnt_dec  = cnt_q - 8'd1;
  // start of the next row, taken with the stride in effect now
  assign row_inc  = (AW+1)'(row_q) + (AW+1)'(1);
  assign eol_prod = PRODW'(row_inc) * PRODW'(stride_q);

  always_comb begin
    phase_d   = phase_q;
    next_addr = addr_w;
    row_d     = row_q;
    cnt_d     = cnt_q;
    dx_d      = dx_q;
    pad_d     = pad_q;
    have      = 1'b0;
    done      = 1'b0;
    f_len     = '0;
    room      = (addr_w < end_w) ? (end_w - addr_w) : '0;
    unique case (phase_q)
      PH_COUNT: begin
        if (b == 8'd0) begin
          phase_d = PH_ESC;
        end else begin
          cnt_d   = b;
          phase_d = PH_VALUE;
        end
      end
      PH_VALUE: begin
        f_len     = (SUMW'(cnt_q) > room) ? room : SUMW'(cnt_q);
        have      = 1'b1;
        next_addr = addr_w + f_len;
        phase_d   = PH_COUNT;
      end
      PH_ESC: begin
        priority if (b == ESC_EOL) begin
          row_d     = row_q + AW'(1);
          next_addr = (eol_prod >= PRODW'(end_q)) ? end_w : SUMW'(eol_prod);
          phase_d   = PH_COUNT;
        end else if (b == ESC_EOB) begin
          done = 1'b1;
        end else if (b == ESC_DELTA) begin
          phase_d = PH_DX;
        end else begin
          cnt_d   = b;
          pad_d   = b[0];
          phase_d = PH_ABS;
        end
      end
      PH_DX: begin
        dx_d    = b;
        phase_d = PH_DY;
      end
      PH_DY: begin
        next_addr = addr_w + SUMW'(dx_q) + dy_off;
        row_d     = row_q + AW'(b);
        phase_d   = PH_COUNT;
      end
      PH_ABS: begin
        if (addr_w < end_w) begin
          have      = 1'b1;
          f_len     = SUMW'(1);
          next_addr = addr_w + SUMW'(1);
        end
        cnt_d = cnt_dec;
        if (cnt_dec == 8'd0) begin
          phase_d = pad_q ? PH_PAD : PH_COUNT;
        end
      end
      default: begin
        phase_d = PH_COUNT;
      end
    endcase
    if (next_addr >= end_w || in_data_i.last_byte) begin
      done = 1'b1;
    end
    addr_d = AW'(next_addr);
  end

  assign res_valid_o        = have || done;
  assign res_o.dest_address = have ? ADDR_W'(addr_q) : '0;
  assign res_o.run_length   = have ? f_len[7:0] : '0;
  assign res_o.pixel_value  = have ? b : '0;
  assign res_o.finished     = done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_COUNT;
      addr_q  <= '0;
      row_q   <= '0;
      cnt_q   <= '0;
      dx_q    <= '0;
      pad_q   <= 1'b0;
    end else if (accept_i) begin
      if (done) begin
        phase_q <= PH_COUNT;
        addr_q  <= '0;
        row_q   <= '0;
        cnt_q   <= '0;
        dx_q    <= '0;
        pad_q   <= 1'b0;
      end else begin
        phase_q <= phase_d;
        addr_q  <= addr_d;
        row_q   <= row_d;
        cnt_q   <= cnt_d;
        dx_q    <= dx_d;
        pad_q   <= pad_d;
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/brle8_checker.sv
`default_nettype none

module brle8_checker import brle8_pkg::*; (
  input wire logic                 clk_i,
  input wire logic                 rst_ni,
  input wire logic                 in_valid_i,
  input wire logic                 in_ready_o,
  input wire logic                 out_valid_o,
  input wire logic                 out_ready_i,
  input wire out_t                 out_data_o
);

  // a pending result holds until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("output transaction dropped or changed while stalled");

  // a fill that does not end decoding always writes pixels
  a_fill_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.finished |-> out_data_o.run_length != 8'd0)
    else $error("empty fill without finished");

  // nothing appears on the output without an input transaction before it
  a_no_invent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_valid_i && in_ready_o) && !out_valid_o |=> !out_valid_o)
    else $error("result without input transaction");

  // input never stalls while the output buffer is empty
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled with empty output");

endmodule

bind bmp_rle8_decoder brle8_checker u_brle8_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire
